FILE: design/olt_pkg.sv
package olt_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int KEY_WIDTH_DEF = 32;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NULL     = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic       load;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       rd_pos;
        logic       wr_en;
        logic       wr_shift;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_found;
        logic       res_value;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       key_zero;
        logic       full;
        logic       pos_ok;
        logic       idx_end;
        logic       match;
    } t_sts;

endpackage

FILE: design/olt_dp.sv
module olt_dp #(
    parameter int DEPTH     = olt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = olt_pkg::KEY_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  olt_pkg::t_cmd i_cmd,
    output olt_pkg::t_sts o_sts,
    input  logic [1:0]    i_opcode,
    input  logic [31:0]   i_key_value,
    input  logic [7:0]    i_position,
    output logic [1:0]    o_status,
    output logic [7:0]    o_found_position,
    output logic [31:0]   o_read_value,
    output logic [8:0]    o_entry_total
);
    import olt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // keys arrive on a 32-bit port; only the low min(KEY_WIDTH, 32) bits survive
    localparam int SW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

    logic [SW-1:0] r_mem [DEPTH];
    logic [SW-1:0] r_rdata;
    logic [SW-1:0] r_key;
    logic [1:0]    r_op;
    logic [7:0]    r_pos;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [1:0]    r_res_status;
    logic [7:0]    r_res_found;
    logic [31:0]   r_res_value;
    logic [1:0]    r_status;
    logic [7:0]    r_found;
    logic [31:0]   r_value;
    logic [8:0]    r_total;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] wr_data;

    assign rd_addr = i_cmd.rd_pos ? AW'(r_pos) : AW'(r_idx);
    // shift writes trail the read index by two: one for the index step, one for the gap
    assign wr_addr = i_cmd.wr_shift ? AW'(r_idx - CW'(2)) : AW'(r_count);
    assign wr_data = i_cmd.wr_shift ? r_rdata : r_key;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= SW'(i_key_value);
            r_op  <= i_opcode;
            r_pos <= i_position;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_found  <= i_cmd.res_found ? 8'(r_idx - CW'(1)) : 8'd0;
            r_res_value  <= i_cmd.res_value ? 32'(r_rdata) : 32'd0;
        end
        if (i_cmd.out_load) begin
            r_status <= r_res_status;
            r_found  <= r_res_found;
            r_value  <= r_res_value;
            // freeze the count with the result; the next item may change it
            r_total  <= 9'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.key_zero = (r_key == '0);
    assign o_sts.full     = (r_count == CW'(DEPTH));
    assign o_sts.pos_ok   = (32'(r_pos) < 32'(r_count));
    assign o_sts.idx_end  = (r_idx >= r_count);
    assign o_sts.match    = (r_rdata == r_key);

    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_read_value     = r_value;
    assign o_entry_total    = r_total;

endmodule

FILE: design/olt_ctrl.sv
module olt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  olt_pkg::t_sts i_sts,
    output olt_pkg::t_cmd o_cmd
);
    import olt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_pend, n_pend;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_pend  = r_pend;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op) inside
                    OP_APPEND: begin
                        cmd.res_load = 1'b1;
                        if (i_sts.key_zero) begin
                            cmd.res_status = ST_NULL;
                        end else if (i_sts.full) begin
                            cmd.res_status = ST_FULL;
                        end else begin
                            cmd.res_status = ST_OK;
                            cmd.wr_en      = 1'b1;
                            cmd.cnt_inc    = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    OP_REMOVE, OP_FIND: begin
                        if (i_sts.key_zero) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = (i_sts.op == OP_REMOVE) ? ST_NULL : ST_NOTFOUND;
                            n_state        = S_DONE;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            n_pend      = 1'b0;
                            n_state     = S_SCAN;
                        end
                    end
                    default: begin
                        if (i_sts.pos_ok) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_pos = 1'b1;
                            n_state    = S_RDWAIT;
                        end else begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_NOTFOUND;
                            n_state        = S_DONE;
                        end
                    end
                endcase
            end
            S_RDWAIT: begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_value  = 1'b1;
                n_state        = S_DONE;
            end
            S_SCAN: begin
                if (r_pend && i_sts.match) begin
                    if (i_sts.op == OP_REMOVE) begin
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_OK;
                        cmd.res_found  = 1'b1;
                        n_state        = S_DONE;
                    end
                end else if (i_sts.idx_end) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOTFOUND;
                    n_state        = S_DONE;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.idx_inc = 1'b1;
                    n_pend      = 1'b1;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_shift = 1'b1;
                end
                if (!i_sts.idx_end) begin
                    cmd.rd_en   = 1'b1;
                    cmd.idx_inc = 1'b1;
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        cmd.cnt_dec    = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_OK;
                        n_state        = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/ordered_list_table_top.sv
// Operations: append writes at dispatch, read passes through a read-wait state, find
//   scans to the match, remove scans to it and then moves one entry per cycle down the list.
// Throughput: one item at a time; the next transfer is taken once the current
//   result sits in the output register, so the one-entry-per-cycle walk and output back-pressure set it.
// Reset (synchronous, active low) empties the list and clears the handshake;
//   the list memory is not cleared, entries past the count are never read.
module ordered_list_table_top #(
    parameter int DEPTH     = olt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = olt_pkg::KEY_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_key_value,
    input  logic [7:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_found_position,
    output logic [31:0] o_read_value,
    output logic [8:0]  o_entry_total
);
    import olt_pkg::*;

    // Controller steps the list through dispatch, scan, shift and result
    // hand-off; the datapath holds the list memory, the count, the scan
    // index and both the pending and the output result registers.
    t_cmd cmd;
    t_sts sts;

    olt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Remove runs a pipelined scan (read one entry, compare it the next
    // cycle), then moves each later entry down one slot while reading ahead.
    olt_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_opcode         (i_opcode),
        .i_key_value      (i_key_value),
        .i_position       (i_position),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_read_value     (o_read_value),
        .o_entry_total    (o_entry_total)
    );

`ifndef SYNTHESIS
    // a transfer in always starts work, so the block stops taking items
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block still ready after taking an item");

    // a failed operation reports no position and no key
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_found_position == 8'd0 && o_read_value == 32'd0))
        else $error("failed result carries a position or value");

    // a full list is reported only with the count at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_entry_total == 9'(DEPTH)))
        else $error("list full reported below capacity");

    // a loaded result is presented the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("result loaded but not presented");
`endif

endmodule
